>>> src/bfa_pkg.sv
// shared constants, payload widths and control structs for the best-fit allocator
`default_nettype none

package bfa_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int SIZE_BITS   = 16;

  // entry index and scan counter widths
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // fixed field widths on the ports
  localparam int CMD_W   = 1;
  localparam int BIDX_W  = 4;
  localparam int REQ_W   = 16;
  localparam int CFG_W   = 5;
  localparam int NUM_W   = 5;
  localparam int OSIZE_W = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // sequencer to scan unit
  typedef struct packed {
    logic  load_en;
    idx_t  load_idx;
    size_t load_size;
    logic  start;
    size_t req;
    cnt_t  limit;
    logic  commit;
  } scan_ctrl_t;

  // scan unit back to sequencer
  typedef struct packed {
    logic  busy;
    logic  have;
    idx_t  best_idx;
    size_t best_size;
    size_t req;
  } scan_stat_t;

endpackage

`default_nettype wire

>>> src/bfa_if.sv
// valid/ready channel interfaces for input items, results and configuration
`default_nettype none

interface bfa_in_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [BIDX_W-1:0]  block_index;
  logic [REQ_W-1:0]   req_size;

  modport source (output valid, output cmd, output block_index, output req_size,
                  input ready);
  modport sink   (input valid, input cmd, input block_index, input req_size,
                  output ready);
endinterface

interface bfa_out_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [NUM_W-1:0]   block_number;
  logic [OSIZE_W-1:0] chosen_size;
  logic [OSIZE_W-1:0] fragment;

  modport source (output valid, output found, output block_number,
                  output chosen_size, output fragment, input ready);
  modport sink   (input valid, input found, input block_number,
                  input chosen_size, input fragment, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] block_count;

  modport source (output valid, output block_count, input ready);
  modport sink   (input valid, input block_count, output ready);
endinterface

`default_nettype wire

>>> src/best_fit_block_allocator_top.sv
// best-fit block allocator: sequencer, config register and result register
//
//   channel  dir  transfer moves                          when
//   in_ch    in   cmd, block_index, req_size              valid & ready
//   out_ch   out  found, block_number, chosen_size, frag  valid & ready
//   cfg_ch   in   block_count                             valid & ready
//
// a load writes the table on its transfer; an allocate passes from its transfer
// to the result register through its steps accept, scan and commit
// the compare unit scans min(block_count, 16) table entries, one per cycle
// reset clears the allocated marks, block_count, the sequencer and out valid
// block sizes are not reset; an entry must be loaded before a scan reads it
// a waiting result does not block new input; a scan that finishes while the
// result register is still full holds in commit until out_ch takes it
`default_nettype none

module best_fit_block_allocator_top import bfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bfa_in_if.sink    in_ch,
  bfa_out_if.source out_ch,
  bfa_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] count_r, count_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic               found_r,     found_nxt;
  logic [NUM_W-1:0]   num_r,       num_nxt;
  logic [OSIZE_W-1:0] csize_r,     csize_nxt;
  logic [OSIZE_W-1:0] frag_r,      frag_nxt;

  scan_ctrl_t ctrl;
  scan_stat_t stat;

  logic         in_xfer;
  logic         load_ok;
  logic         out_free;
  cnt_t         limit;
  logic [IDX_W:0] num_wide;
  size_t        frag_wide;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  // loads beyond the table are dropped
  assign load_ok = (int'(in_ch.block_index) < TABLE_DEPTH);

  // a count above the table size scans the whole table
  assign limit = (int'(count_r) > TABLE_DEPTH) ? cnt_t'(TABLE_DEPTH) : cnt_t'(count_r);

  // result register is free once empty or being drained
  assign out_free = !out_valid_r || out_ch.ready;

  assign num_wide  = {1'b0, stat.best_idx} + (IDX_W+1)'(1);
  assign frag_wide = stat.best_size - stat.req;

  assign count_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.block_count : count_r;

  always_comb begin
    state_nxt      = state_r;
    ctrl.load_en   = 1'b0;
    ctrl.load_idx  = idx_t'(in_ch.block_index);
    ctrl.load_size = size_t'(in_ch.req_size);
    ctrl.start     = 1'b0;
    ctrl.req       = size_t'(in_ch.req_size);
    ctrl.limit     = limit;
    ctrl.commit    = 1'b0;
    out_valid_nxt  = out_valid_r;
    found_nxt      = found_r;
    num_nxt        = num_r;
    csize_nxt      = csize_r;
    frag_nxt       = frag_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          priority if (in_ch.cmd == CMD_ALLOC) begin
            ctrl.start = 1'b1;
            state_nxt  = ST_SCAN;
          end else begin
            ctrl.load_en = load_ok;
          end
        end
      end
      ST_SCAN: begin
        if (!stat.busy) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          ctrl.commit   = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.have) begin
            found_nxt = 1'b1;
            num_nxt   = NUM_W'(num_wide);
            csize_nxt = OSIZE_W'(stat.best_size);
            frag_nxt  = OSIZE_W'(frag_wide);
          end else begin
            found_nxt = 1'b0;
            num_nxt   = '0;
            csize_nxt = '0;
            frag_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    num_r   <= num_nxt;
    csize_r <= csize_nxt;
    frag_r  <= frag_nxt;
  end

  bfa_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = found_r;
  assign out_ch.block_number = num_r;
  assign out_ch.chosen_size  = csize_r;
  assign out_ch.fragment     = frag_r;

endmodule

`default_nettype wire

>>> src/bfa_scan.sv
// block table and the shared compare unit that walks it one entry per cycle
`default_nettype none

module bfa_scan import bfa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  scan_ctrl_t ctrl,
  output scan_stat_t stat
);

  size_t                  size_mem_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] taken_r, taken_nxt;

  logic  busy_r,      busy_nxt;
  logic  have_r,      have_nxt;
  cnt_t  ptr_r,       ptr_nxt;
  cnt_t  limit_r,     limit_nxt;
  idx_t  best_idx_r,  best_idx_nxt;
  size_t best_size_r, best_size_nxt;
  size_t req_r,       req_nxt;

  idx_t  cur_idx;
  size_t cur_size_r;
  logic  fits;
  logic  better;
  cnt_t  ptr_inc;

  // table writes; the read is registered at the next scan address so the
  // data lines up with ptr_r (no load can land while a scan runs)
  always_ff @(posedge clk) begin
    if (ctrl.load_en) begin
      size_mem_r[ctrl.load_idx] <= ctrl.load_size;
    end
    cur_size_r <= size_mem_r[ptr_nxt[IDX_W-1:0]];
  end

  always_comb begin
    taken_nxt = taken_r;
    if (ctrl.load_en) begin
      taken_nxt[ctrl.load_idx] = 1'b0;
    end
    if (ctrl.commit && have_r) begin
      taken_nxt[best_idx_r] = 1'b1;
    end
  end

  // one entry per cycle through the compare unit
  assign cur_idx  = ptr_r[IDX_W-1:0];
  assign fits     = !taken_r[cur_idx] && (cur_size_r >= req_r);
  assign better   = !have_r || (cur_size_r < best_size_r);
  assign ptr_inc  = ptr_r + cnt_t'(1);

  always_comb begin
    busy_nxt      = busy_r;
    have_nxt      = have_r;
    ptr_nxt       = ptr_r;
    limit_nxt     = limit_r;
    best_idx_nxt  = best_idx_r;
    best_size_nxt = best_size_r;
    req_nxt       = req_r;
    if (ctrl.start) begin
      ptr_nxt   = '0;
      have_nxt  = 1'b0;
      req_nxt   = ctrl.req;
      limit_nxt = ctrl.limit;
      busy_nxt  = (ctrl.limit != '0);
    end else if (busy_r) begin
      if (fits && better) begin
        have_nxt      = 1'b1;
        best_idx_nxt  = cur_idx;
        best_size_nxt = cur_size_r;
      end
      ptr_nxt = ptr_inc;
      if (ptr_inc == limit_r) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= '0;
      busy_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      taken_r <= taken_nxt;
      busy_r  <= busy_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    limit_r     <= limit_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    req_r       <= req_nxt;
  end

  assign stat.busy      = busy_r;
  assign stat.have      = have_r;
  assign stat.best_idx  = best_idx_r;
  assign stat.best_size = best_size_r;
  assign stat.req       = req_r;

endmodule

`default_nettype wire

>>> src/bfa_checker.sv
// port-level checks on the best-fit allocator, bound to the top level
`default_nettype none

module bfa_checker import bfa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [CMD_W-1:0]   in_cmd,
  input logic               out_valid,
  input logic               out_ready,
  input logic               found,
  input logic [NUM_W-1:0]   block_number,
  input logic [OSIZE_W-1:0] chosen_size,
  input logic [OSIZE_W-1:0] fragment
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a miss reports all zeros
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> block_number == '0 && chosen_size == '0 && fragment == '0)
    else $error("miss result not all zero");

  // a hit names a real block and its leftover never exceeds its size
  a_hit_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> block_number != '0 && int'(block_number) <= TABLE_DEPTH
                           && fragment <= chosen_size)
    else $error("hit result out of range");

  // an allocate holds off input while it scans
  a_busy_after_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_ALLOC |=> !in_ready)
    else $error("input taken during scan");

endmodule

bind best_fit_block_allocator_top bfa_checker u_bfa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_cmd       (in_ch.cmd),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .found        (out_ch.found),
  .block_number (out_ch.block_number),
  .chosen_size  (out_ch.chosen_size),
  .fragment     (out_ch.fragment)
);

`default_nettype wire
